FILE: hw/rtl/gtd_pkg.sv
// -----------------------------------------------------------------------------
// gtd_pkg
// Shared constants, types and helpers of the greedy tracklet deduplicator.
// -----------------------------------------------------------------------------
`default_nettype none

package gtd_pkg;

   localparam int PAIR_SLOTS_DEF = 64;
   localparam int HIT_SLOTS_DEF  = 1024;
   localparam int DIST_BITS_DEF  = 24;
   localparam int IDX_BITS       = 10;
   localparam int EPOCH_BITS     = 8;

   localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
   localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;
   localparam logic [EPOCH_BITS-1:0] EPOCH_NONE  = '0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_LOAD,
      ST_READ,
      ST_CHECK,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } cell_ctrl_type;

   // hit index reduced below slots by binary long reduction (slots >= 8)
   function automatic logic [IDX_BITS-1:0] hit_reduce(input logic [IDX_BITS-1:0] idx,
                                                      input int unsigned slots);
      logic [IDX_BITS-1:0] r;
      logic [31:0]         step;
      r = idx;
      for (int k = 6; k >= 0; k--) begin
         step = 32'(slots) << k;
         if (step < 32'(2**IDX_BITS) && 32'(r) >= step) begin
            r = r - IDX_BITS'(step);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gtd_cell.sv
// -----------------------------------------------------------------------------
// gtd_cell
// One slot of the sorted insertion chain: holds a pair and its magnitude.
// -----------------------------------------------------------------------------
`default_nettype none

module gtd_cell
   import gtd_pkg::*;
#(
   parameter int DW = DIST_BITS_DEF + 2 * IDX_BITS,
   parameter int MW = DIST_BITS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire logic [DW-1:0] new_data,
   input  wire logic [MW-1:0] new_mag,
   input  wire logic [DW-1:0] left_data,
   input  wire logic [MW-1:0] left_mag,
   input  wire logic          left_valid,
   input  wire logic          left_displace,
   input  wire logic [DW-1:0] right_data,
   input  wire logic [MW-1:0] right_mag,
   input  wire logic          right_valid,
   output logic [DW-1:0]      data_o,
   output logic [MW-1:0]      mag_o,
   output logic               valid_o,
   output logic               displace_o
);

   logic [DW-1:0] data_ff, data_in;
   logic [MW-1:0] mag_ff, mag_in;
   logic          valid_ff, valid_in;

   // strictly larger entries move right, so equal magnitudes keep arrival order
   assign displace_o = ctrl.insert && valid_ff && (new_mag < mag_ff);

   always_comb begin
      data_in  = data_ff;
      mag_in   = mag_ff;
      valid_in = valid_ff;
      if (ctrl.pop) begin
         data_in  = right_data;
         mag_in   = right_mag;
         valid_in = right_valid;
      end else if (ctrl.insert) begin
         if (left_displace) begin
            data_in  = left_data;
            mag_in   = left_mag;
            valid_in = 1'b1;
         end else if (displace_o || (!valid_ff && left_valid)) begin
            data_in  = new_data;
            mag_in   = new_mag;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      mag_ff  <= mag_in;
   end

   assign data_o  = data_ff;
   assign mag_o   = mag_ff;
   assign valid_o = valid_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/gtd_used_map.sv
// -----------------------------------------------------------------------------
// gtd_used_map
// Hit-used map: one epoch tag per hit slot, registered read.
// -----------------------------------------------------------------------------
`default_nettype none

module gtd_used_map
   import gtd_pkg::*;
#(
   parameter  int HIT_SLOTS = HIT_SLOTS_DEF,
   localparam int AW        = $clog2(HIT_SLOTS)
) (
   input  wire logic                  clock,
   input  wire logic                  rd_en,
   input  wire logic [AW-1:0]         rd_addr,
   output logic [EPOCH_BITS-1:0]      rd_tag,
   input  wire logic                  wr_en,
   input  wire logic [AW-1:0]         wr_addr,
   input  wire logic [EPOCH_BITS-1:0] wr_tag
);

   logic [EPOCH_BITS-1:0] mem [HIT_SLOTS];
   logic [EPOCH_BITS-1:0] rd_tag_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_tag_ff <= mem[rd_addr];
      end
   end

   assign rd_tag = rd_tag_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/greedy_tracklet_deduplicator_top.sv
// -----------------------------------------------------------------------------
// greedy_tracklet_deduplicator_top
// Greedy matching of hit pairs by distance magnitude; one-to-one with check_second_layer set.
// -----------------------------------------------------------------------------
// Pairs of one event stream in on req_*, one item per cycle, into a sorted
// insertion chain of PAIR_SLOTS cells (ascending magnitude, ties in arrival
// order). Pairs beyond PAIR_SLOTS are dropped and flag overflow on every
// result of the event. The item with req_tlast starts selection: req_tready
// drops, the chain is drained from its head, and each pair takes a read step
// (pop plus map read), then a check step (check, and mark if kept), since
// both hit-used maps have a registered read; a kept pair waits longer while
// the output register is held by rsp_tready. An empty-chain check, then a
// flush close the event. Kept pairs leave on rsp_* in sorted order,
// rsp_tlast on the last one; an output register lets the final result wait
// while the next event loads. Used maps are not swept per event: each entry
// holds the epoch of the event that marked it. A sweep over HIT_SLOTS entries
// runs after reset and after every 255 events, with req_tready low.
// csr_wr_data sets check_second_layer (reset 1); write it only while idle.
// -----------------------------------------------------------------------------
`default_nettype none

module greedy_tracklet_deduplicator_top
   import gtd_pkg::*;
#(
   parameter  int PAIR_SLOTS = PAIR_SLOTS_DEF,
   parameter  int HIT_SLOTS  = HIT_SLOTS_DEF,
   parameter  int DIST_BITS  = DIST_BITS_DEF,
   localparam int PAIR_W     = DIST_BITS + 2 * IDX_BITS,
   localparam int DATA_W     = ((PAIR_W + 7) / 8) * 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // configuration
   input  wire logic              csr_wr_en,
   input  wire logic              csr_wr_data,     // check_second_layer
   // pair items in
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [DATA_W-1:0] req_tdata,       // distance, first_hit_index,
                                                   // second_hit_index, zero fill
   input  wire logic              req_tlast,       // last pair of the event
   // kept pairs out
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [DATA_W-1:0]      rsp_tdata,       // kept_distance, kept_first_index,
                                                   // kept_second_index, zero fill
   output logic                   rsp_tuser,       // overflow
   output logic                   rsp_tlast        // last_of_run
);

   localparam int CNT_W  = $clog2(PAIR_SLOTS + 1);
   localparam int HIT_AW = $clog2(HIT_SLOTS);

   // ---------------------------------------------------------------- control regs
   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic                  check_ff;
   logic [EPOCH_BITS-1:0] epoch_ff, epoch_in;
   logic [HIT_AW-1:0]     clr_addr_ff, clr_addr_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // ---------------------------------------------------------------- payload regs
   logic [PAIR_W-1:0]     cur_data_ff, cur_data_in;
   logic [HIT_AW-1:0]     cur_a_ff, cur_a_in;
   logic [HIT_AW-1:0]     cur_b_ff, cur_b_in;
   logic [PAIR_W-1:0]     pend_data_ff, pend_data_in;
   logic [PAIR_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   // ---------------------------------------------------------------- input side
   logic                         req_fire;
   logic signed [DIST_BITS-1:0]  in_dist;
   logic [DIST_BITS-1:0]         in_mag;
   logic [PAIR_W-1:0]            in_data;
   logic                         store_full;

   assign req_fire   = req_tvalid && req_tready;
   assign in_data    = req_tdata[PAIR_W-1:0];
   assign in_dist    = req_tdata[DIST_BITS-1:0];
   // two's complement magnitude; the most negative value maps to 2^(DIST_BITS-1)
   assign in_mag     = in_dist[DIST_BITS-1] ? (~in_dist + DIST_BITS'(1)) : in_dist;
   assign store_full = (count_ff == CNT_W'(PAIR_SLOTS));

   // ---------------------------------------------------------------- sort chain
   // index 0 and PAIR_SLOTS+1 are the chain ends; cell g sits at index g+1
   cell_ctrl_type        cell_ctrl;
   logic [PAIR_W-1:0]    chain_data     [PAIR_SLOTS+2];
   logic [DIST_BITS-1:0] chain_mag      [PAIR_SLOTS+2];
   logic                 chain_valid    [PAIR_SLOTS+2];
   logic                 chain_displace [PAIR_SLOTS+2];
   logic [PAIR_SLOTS-1:0] cell_valid_vec;

   assign chain_data[0]                 = '0;
   assign chain_mag[0]                  = '0;
   assign chain_valid[0]                = 1'b1;
   assign chain_displace[0]             = 1'b0;
   assign chain_data[PAIR_SLOTS+1]      = '0;
   assign chain_mag[PAIR_SLOTS+1]       = '0;
   assign chain_valid[PAIR_SLOTS+1]     = 1'b0;
   assign chain_displace[PAIR_SLOTS+1]  = 1'b0;

   for (genvar g = 0; g < PAIR_SLOTS; g++) begin : g_cell
      gtd_cell #(
         .DW (PAIR_W),
         .MW (DIST_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (cell_ctrl),
         .new_data      (in_data),
         .new_mag       (in_mag),
         .left_data     (chain_data[g]),
         .left_mag      (chain_mag[g]),
         .left_valid    (chain_valid[g]),
         .left_displace (chain_displace[g]),
         .right_data    (chain_data[g+2]),
         .right_mag     (chain_mag[g+2]),
         .right_valid   (chain_valid[g+2]),
         .data_o        (chain_data[g+1]),
         .mag_o         (chain_mag[g+1]),
         .valid_o       (chain_valid[g+1]),
         .displace_o    (chain_displace[g+1])
      );
      assign cell_valid_vec[g] = chain_valid[g+1];
   end

   // ---------------------------------------------------------------- used maps
   logic [IDX_BITS-1:0]   head_first, head_second;
   logic                  map_rd_en;
   logic [HIT_AW-1:0]     head_a, head_b;
   logic [EPOCH_BITS-1:0] first_tag, second_tag;
   logic                  first_wr_en, second_wr_en;
   logic [HIT_AW-1:0]     first_wr_addr, second_wr_addr;
   logic [EPOCH_BITS-1:0] map_wr_tag;
   logic                  pair_used;

   assign head_first  = chain_data[1][DIST_BITS +: IDX_BITS];
   assign head_second = chain_data[1][DIST_BITS + IDX_BITS +: IDX_BITS];
   assign head_a      = HIT_AW'(hit_reduce(head_first, HIT_SLOTS));
   assign head_b      = HIT_AW'(hit_reduce(head_second, HIT_SLOTS));
   assign pair_used   = (first_tag == epoch_ff) || (second_tag == epoch_ff);

   gtd_used_map #(
      .HIT_SLOTS (HIT_SLOTS)
   ) u_first_map (
      .clock   (clock),
      .rd_en   (map_rd_en),
      .rd_addr (head_a),
      .rd_tag  (first_tag),
      .wr_en   (first_wr_en),
      .wr_addr (first_wr_addr),
      .wr_tag  (map_wr_tag)
   );

   gtd_used_map #(
      .HIT_SLOTS (HIT_SLOTS)
   ) u_second_map (
      .clock   (clock),
      .rd_en   (map_rd_en),
      .rd_addr (head_b),
      .rd_tag  (second_tag),
      .wr_en   (second_wr_en),
      .wr_addr (second_wr_addr),
      .wr_tag  (map_wr_tag)
   );

   // ---------------------------------------------------------------- sequencer
   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      ovf_in         = ovf_ff;
      epoch_in       = epoch_ff;
      clr_addr_in    = clr_addr_ff;
      pend_valid_in  = pend_valid_ff;
      pend_data_in   = pend_data_ff;
      cur_data_in    = cur_data_ff;
      cur_a_in       = cur_a_ff;
      cur_b_in       = cur_b_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      cell_ctrl      = '0;
      req_tready     = 1'b0;
      map_rd_en      = 1'b0;
      first_wr_en    = 1'b0;
      second_wr_en   = 1'b0;
      first_wr_addr  = cur_a_ff;
      second_wr_addr = cur_b_ff;
      map_wr_tag     = epoch_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            first_wr_en    = 1'b1;
            second_wr_en   = 1'b1;
            first_wr_addr  = clr_addr_ff;
            second_wr_addr = clr_addr_ff;
            map_wr_tag     = EPOCH_NONE;
            clr_addr_in    = clr_addr_ff + HIT_AW'(1);
            if (clr_addr_ff == HIT_AW'(HIT_SLOTS - 1)) begin
               clr_addr_in = '0;
               epoch_in    = EPOCH_FIRST;
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_fire) begin
               if (store_full) begin
                  ovf_in = 1'b1;
               end else begin
                  cell_ctrl.insert = 1'b1;
                  count_in         = count_ff + CNT_W'(1);
               end
               if (req_tlast) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            if (count_ff == '0) begin
               state_in = ST_FLUSH;
            end else begin
               map_rd_en     = 1'b1;
               cell_ctrl.pop = 1'b1;
               count_in      = count_ff - CNT_W'(1);
               cur_data_in   = chain_data[1];
               cur_a_in      = head_a;
               cur_b_in      = head_b;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (pair_used) begin
               state_in = ST_READ;
            end else if (!pend_valid_ff || out_free) begin
               // keep: mark hits, hold pair until we know whether it is the last
               first_wr_en   = 1'b1;
               second_wr_en  = check_ff;
               pend_valid_in = 1'b1;
               pend_data_in  = cur_data_ff;
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = pend_data_ff;
                  rsp_last_in  = 1'b0;
                  rsp_ovf_in   = ovf_ff;
               end
               state_in = ST_READ;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = pend_data_ff;
                  rsp_last_in  = 1'b1;
                  rsp_ovf_in   = ovf_ff;
               end
               pend_valid_in = 1'b0;
               ovf_in        = 1'b0;
               epoch_in      = epoch_ff + EPOCH_BITS'(1);
               state_in      = (epoch_ff == EPOCH_LAST) ? ST_CLEAR : ST_LOAD;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         check_ff      <= 1'b1;
         epoch_ff      <= EPOCH_FIRST;
         clr_addr_ff   <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         epoch_ff      <= epoch_in;
         clr_addr_ff   <= clr_addr_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            check_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_data_ff  <= cur_data_in;
      cur_a_ff     <= cur_a_in;
      cur_b_ff     <= cur_b_in;
      pend_data_ff <= pend_data_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // ---------------------------------------------------------------- outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rsp_data_ff);
   assign rsp_tuser  = rsp_ovf_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------- checks
`ifndef SYNTH
   // chain occupancy is contiguous from the head and matches the pair count
   a_chain_count: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid_vec) == count_ff)
      else $error("chain occupancy differs from pair count");

   a_chain_packed: assert property (@(posedge clock) disable iff (reset)
      ((cell_valid_vec + PAIR_SLOTS'(1)) & cell_valid_vec) == '0)
      else $error("chain has a hole");

   // no held result survives into the next event
   a_pend_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD || state_ff == ST_CLEAR) |-> !pend_valid_ff)
      else $error("pending kept pair left over");

   // the unmarked tag never serves as a live epoch
   a_epoch_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR) |-> (epoch_ff != EPOCH_NONE))
      else $error("epoch zero in use");
`endif

endmodule

`default_nettype wire

FILE: dv/greedy_tracklet_deduplicator_top_tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// greedy_tracklet_deduplicator_top_tb
// Self-checking bench: pair events in on req_*, kept pairs checked on rsp_*.
// A built-in predictor stable-sorts each event by distance magnitude, runs the
// greedy hit-used selection and queues the kept pairs in order. Directed events
// cover extremes, ties and layer conflicts; random events of varied size,
// index spread and tie density follow under both check_second_layer settings,
// then a long stream of one-pair events walks through the epoch rollover.
// -----------------------------------------------------------------------------
module greedy_tracklet_deduplicator_top_tb;
   import gtd_pkg::*;

   localparam int DATA_W             = ((DIST_BITS_DEF + 2 * IDX_BITS + 7) / 8) * 8;
   localparam int FIRST_LSB          = DIST_BITS_DEF;
   localparam int SECOND_LSB         = DIST_BITS_DEF + IDX_BITS;
   // drain of a full store plus output register, with margin
   localparam int SETTLE_CYCLES      = 200;
   // covers the HIT_SLOTS sweep, a full drain and worst-case sink stalls
   localparam int WATCHDOG_LIMIT     = 5000;
   localparam int RANDOM_PHASES      = 2;
   localparam int RANDOM_PHASE_PAIRS = 12;
   // events overall; past 255 so the periodic map sweep is crossed
   localparam int EVENT_TARGET       = 262;

   typedef logic [DIST_BITS_DEF-1:0] dist_type;
   typedef logic [IDX_BITS-1:0]      hit_idx_type;

   localparam dist_type DIST_MAX = {1'b0, {(DIST_BITS_DEF-1){1'b1}}};
   localparam dist_type DIST_MIN = {1'b1, {(DIST_BITS_DEF-1){1'b0}}};
   localparam hit_idx_type IDX_MAX = '1;

   typedef struct packed {
      dist_type    pair_dist;
      hit_idx_type first_hit;
      hit_idx_type second_hit;
   } tracklet_type;

   typedef struct packed {
      dist_type    pair_dist;
      hit_idx_type first_hit;
      hit_idx_type second_hit;
      logic        overflow;
      logic        run_end;
   } kept_tracklet_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              csr_wr_en   = 1'b0;
   logic              csr_wr_data = 1'b0;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata   = '0;   // distance, first_hit_index, second_hit_index, fill
   logic              req_tlast   = 1'b0;  // last pair of the event
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;           // kept_distance, kept_first_index,
                                           // kept_second_index, fill
   logic              rsp_tuser;           // overflow
   logic              rsp_tlast;           // last_of_run

   // predictor state: pairs of the open event and its overflow flag
   tracklet_type      event_pairs [PAIR_SLOTS_DEF];
   int                event_fill         = 0;
   bit                event_overflow     = 1'b0;
   bit                second_layer_check = 1'b1;
   int                events_done        = 0;
   kept_tracklet_type kept_expect_q [$];
   int                error_count        = 0;

   // burst modes: no idle cycles on that side while set
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;

   greedy_tracklet_deduplicator_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // most negative value has the largest magnitude (0x800000 unsigned)
   function automatic dist_type dist_magnitude(dist_type raw);
      return raw[DIST_BITS_DEF-1] ? dist_type'(~raw + 1'b1) : raw;
   endfunction

   // stable sort by magnitude, then greedy pick against the hit-used maps
   function automatic void select_kept_pairs();
      int                order [PAIR_SLOTS_DEF];
      bit                first_used [HIT_SLOTS_DEF];
      bit                second_used [HIT_SLOTS_DEF];
      int                kept [PAIR_SLOTS_DEF];
      int                kept_count;
      int                slot;
      int                a;
      int                b;
      kept_tracklet_type item;
      kept_count = 0;
      for (int h = 0; h < HIT_SLOTS_DEF; h++) begin
         first_used[h]  = 1'b0;
         second_used[h] = 1'b0;
      end
      for (int i = 0; i < event_fill; i++) begin
         slot = i;
         while (slot > 0 && dist_magnitude(event_pairs[i].pair_dist) <
                            dist_magnitude(event_pairs[order[slot-1]].pair_dist)) begin
            order[slot] = order[slot-1];
            slot--;
         end
         order[slot] = i;
      end
      for (int i = 0; i < event_fill; i++) begin
         a = int'(event_pairs[order[i]].first_hit) % HIT_SLOTS_DEF;
         b = int'(event_pairs[order[i]].second_hit) % HIT_SLOTS_DEF;
         if (!first_used[a] && !second_used[b]) begin
            kept[kept_count] = order[i];
            kept_count++;
            first_used[a] = 1'b1;
            if (second_layer_check) begin
               second_used[b] = 1'b1;
            end
         end
      end
      for (int k = 0; k < kept_count; k++) begin
         item.pair_dist  = event_pairs[kept[k]].pair_dist;
         item.first_hit  = event_pairs[kept[k]].first_hit;
         item.second_hit = event_pairs[kept[k]].second_hit;
         item.overflow   = event_overflow;
         item.run_end    = (k == kept_count - 1);
         kept_expect_q   = {kept_expect_q, item};
      end
      event_fill     = 0;
      event_overflow = 1'b0;
      events_done++;
   endfunction

   // store full: pair dropped, overflow flagged; a dropped last still selects
   function automatic void absorb_pair(tracklet_type t, logic is_last);
      if (event_fill < PAIR_SLOTS_DEF) begin
         event_pairs[event_fill] = t;
         event_fill++;
      end else begin
         event_overflow = 1'b1;
      end
      if (is_last) begin
         select_kept_pairs();
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   // one item: random idle cycles, then hold until req_tready; valid drops
   // after the last pair of an event
   task automatic send_pair(dist_type d, hit_idx_type f, hit_idx_type s, logic is_last);
      int           gap;
      tracklet_type t;
      t   = '{pair_dist: d, first_hit: f, second_hit: s};
      gap = req_burst ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'({s, f, d});
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      absorb_pair(t, is_last);
      if (is_last) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   // full-range values, or a tie-heavy mix around zero and the extremes
   function automatic dist_type draw_distance(bit tie_heavy);
      dist_type pick;
      if (!tie_heavy) begin
         return dist_type'($urandom());
      end
      case ($urandom_range(0, 5))
         0:       pick = DIST_MIN;
         1:       pick = DIST_MIN + 1'b1;
         2:       pick = DIST_MAX;
         3:       pick = '0;
         4:       pick = dist_type'($urandom_range(0, 7));
         default: pick = -dist_type'($urandom_range(0, 7));
      endcase
      return pick;
   endfunction

   task automatic send_random_event(int n, int span, bit tie_heavy);
      for (int i = 0; i < n; i++) begin
         send_pair(draw_distance(tie_heavy), hit_idx_type'($urandom_range(0, span)),
                   hit_idx_type'($urandom_range(0, span)), i == n - 1);
      end
   endtask

   task automatic wait_for_drain();
      while (kept_expect_q.size() != 0) @(posedge clock);
   endtask

   // register write only when idle; trailing rejected pairs may still be in
   // selection after the last result, so let the drain time pass first
   task automatic write_second_layer_check(bit value);
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      second_layer_check = value;
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // runs on the reset value of check_second_layer (1)
   task automatic test_directed_extremes();
      // single pair, largest positive distance and all-ones indices
      send_pair(DIST_MAX, IDX_MAX, IDX_MAX, 1'b1);
      // equal magnitudes keep arrival order; most negative sorts last
      send_pair(DIST_MIN,        10'd0, 10'd0, 1'b0);
      send_pair(dist_type'(5),   10'd1, 10'd1, 1'b0);
      send_pair(-dist_type'(5),  10'd2, 10'd2, 1'b0);
      send_pair(dist_type'(5),   10'd3, 10'd3, 1'b0);
      send_pair('0,              10'd4, 10'd4, 1'b1);
      // first-layer conflict, then a second-layer conflict
      send_pair(dist_type'(10),  10'd7, 10'd100, 1'b0);
      send_pair(dist_type'(3),   10'd7, 10'd200, 1'b0);
      send_pair(dist_type'(4),   10'd8, 10'd200, 1'b0);
      send_pair(dist_type'(6),   10'd9, 10'd300, 1'b1);
      // tie at magnitude 1 with index extremes, then a loser on first hit 0
      send_pair('1,              10'd0,   IDX_MAX, 1'b0);
      send_pair(dist_type'(1),   IDX_MAX, 10'd0,   1'b0);
      send_pair(dist_type'(2),   10'd0,   10'd0,   1'b1);
   endtask

   // with the check off, a second-layer hit may be reused
   task automatic test_second_layer_reuse();
      write_second_layer_check(1'b0);
      send_pair(dist_type'(10),  10'd7, 10'd100, 1'b0);
      send_pair(dist_type'(3),   10'd7, 10'd200, 1'b0);
      send_pair(dist_type'(4),   10'd8, 10'd200, 1'b0);
      send_pair(dist_type'(6),   10'd9, 10'd300, 1'b1);
      send_pair(dist_type'(1),   10'd1, 10'd50,  1'b0);
      send_pair(DIST_MIN,        10'd2, 10'd50,  1'b0);
      send_pair(-dist_type'(1),  10'd3, 10'd50,  1'b1);
   endtask

   // exactly full store, then two pairs past it, both dropped
   task automatic test_store_full();
      write_second_layer_check(1'b1);
      send_random_event(PAIR_SLOTS_DEF, 15, 1'b0);
      send_random_event(PAIR_SLOTS_DEF + 2, 31, 1'b1);
   endtask

   task automatic test_random_events();
      int sent;
      int pick;
      int n;
      int span;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_second_layer_check(phase % 2 == 0);
         sent = 0;
         while (sent < RANDOM_PHASE_PAIRS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               n = $urandom_range(1, 4);
            end else if (pick < 85) begin
               n = $urandom_range(5, 12);
            end else if (pick < 97) begin
               n = $urandom_range(13, 30);
            end else begin
               n = $urandom_range(PAIR_SLOTS_DEF - 4, PAIR_SLOTS_DEF + 6);
            end
            // narrow spreads force hit collisions, full spread hits every bit
            case ($urandom_range(0, 2))
               0:       span = 7;
               1:       span = 63;
               default: span = HIT_SLOTS_DEF - 1;
            endcase
            req_burst = ($urandom_range(0, 3) == 0);
            // now and then hold off until every kept pair is out
            if ($urandom_range(0, 9) == 0) begin
               wait_for_drain();
            end
            send_random_event(n, span, 1'($urandom_range(0, 1)));
            sent += n;
         end
      end
   endtask

   // many short events back to back, past the 255-event map sweep
   task automatic test_event_stream();
      write_second_layer_check(1'b1);
      while (events_done < EVENT_TARGET) begin
         req_burst = ($urandom_range(0, 3) != 0);
         send_random_event(1, HIT_SLOTS_DEF - 1, 1'($urandom_range(0, 1)));
      end
   endtask

   // ---------------------------------------------------------------------------
   // Result side: random stalls on rsp_tready, field checks at the rising edge
   // ---------------------------------------------------------------------------

   initial begin : result_sink
      int gap;
      forever begin
         @(negedge clock);
         gap = rsp_burst ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if ($urandom_range(0, 31) == 0) begin
            rsp_burst = !rsp_burst;
         end
      end
   end

   always @(posedge clock) begin : check_kept
      kept_tracklet_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (kept_expect_q.size() == 0) begin
            $error("unexpected kept pair: tdata=%h", rsp_tdata);
            error_count++;
         end else begin
            want = kept_expect_q.pop_front();
            if (rsp_tdata[DIST_BITS_DEF-1:0] !== want.pair_dist) begin
               $error("kept_distance: expected %0d, got %0d", $signed(want.pair_dist),
                      $signed(rsp_tdata[DIST_BITS_DEF-1:0]));
               error_count++;
            end
            if (rsp_tdata[FIRST_LSB +: IDX_BITS] !== want.first_hit) begin
               $error("kept_first_index: expected %0d, got %0d", want.first_hit,
                      rsp_tdata[FIRST_LSB +: IDX_BITS]);
               error_count++;
            end
            if (rsp_tdata[SECOND_LSB +: IDX_BITS] !== want.second_hit) begin
               $error("kept_second_index: expected %0d, got %0d", want.second_hit,
                      rsp_tdata[SECOND_LSB +: IDX_BITS]);
               error_count++;
            end
            if (rsp_tuser !== want.overflow) begin
               $error("overflow: expected %0b, got %0b", want.overflow, rsp_tuser);
               error_count++;
            end
            if (rsp_tlast !== want.run_end) begin
               $error("last_of_run: expected %0b, got %0b", want.run_end, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Watchdog: cycles with no item moving on either side
   // ---------------------------------------------------------------------------

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("greedy_tracklet_deduplicator_top_tb: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------

   initial begin : stimulus
      // reset held first; block sweeps its maps after release
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_second_layer_reuse();
      test_store_full();
      test_random_events();
      test_event_stream();
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("greedy_tracklet_deduplicator_top_tb: PASS");
      end else begin
         $display("greedy_tracklet_deduplicator_top_tb: FAIL");
      end
      $finish;
   end

endmodule
